@@ sv/swhd_pkg.sv @@
// ----------------------------------------------------------------------------
// swhd_pkg
// shared types, constants and the crc byte step for the header deframer
// ----------------------------------------------------------------------------
package swhd_pkg;

  localparam int unsigned WIN_BYTES = 16;
  localparam int unsigned LAST_CELL = 15;

  localparam logic [31:0] SYNC_RESET = 32'hFE45_6688;
  localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] sequence_number;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  // control shared by every cell of the window
  typedef struct packed {
    logic        shift_en;
    logic [31:0] word;
  } cell_bus_t;

  // eight msb-first steps of the crc register, no data folded in
  function automatic logic [31:0] crc_shift8(input logic [31:0] crc_in);
    logic [31:0] c;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ sv/swhd_in_if.sv @@
// ----------------------------------------------------------------------------
// swhd_in_if
// byte request channel into the deframer
// ----------------------------------------------------------------------------
interface swhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/swhd_out_if.sv @@
// ----------------------------------------------------------------------------
// swhd_out_if
// result request channel out of the deframer
// ----------------------------------------------------------------------------
interface swhd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] sequence_number;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output kind, output sequence_number,
                  output payload_length, output payload_byte, output last,
                  input ready);
  modport sink   (input valid, input kind, input sequence_number,
                  input payload_length, input payload_byte, input last,
                  output ready);
endinterface

@@ sv/swhd_cell.sv @@
// ----------------------------------------------------------------------------
// swhd_cell
// one window byte plus, when CRC_EN is set, the running crc of one candidate header start
// ----------------------------------------------------------------------------
module swhd_cell
  import swhd_pkg::*;
#(
  parameter bit CRC_EN  = 1'b0,
  parameter bit SEED_EN = 1'b0,
  parameter bit WORD_EN = 1'b0
) (
  input  logic        clk,
  input  cell_bus_t   bus,
  input  logic [7:0]  byte_in,
  input  logic [31:0] crc_in,
  output logic [7:0]  byte_out,
  output logic [31:0] crc_out
);

  logic [7:0] data_byte;

  always_ff @(posedge clk) begin
    if (bus.shift_en) begin
      data_byte <= byte_in;
    end
  end

  assign byte_out = data_byte;

  generate
    if (CRC_EN) begin : g_crc
      logic [31:0] crc;
      logic [31:0] crc_next;
      logic [31:0] base;

      always_comb begin
        base = SEED_EN ? CRC_INIT : crc_shift8(crc_in);
        crc_next = WORD_EN ? (base ^ bus.word) : base;
      end

      always_ff @(posedge clk) begin
        if (bus.shift_en) begin
          crc <= crc_next;
        end
      end

      assign crc_out = crc;
    end else begin : g_no_crc
      assign crc_out = '0;
    end
  endgenerate

endmodule

@@ sv/sync_word_header_deframer_top.sv @@
// ----------------------------------------------------------------------------
// sync_word_header_deframer_top
// sliding 16-byte window deframer: sync word plus crc-32 header, then payload
// ----------------------------------------------------------------------------
// each result is registered in the output register, or in the skid entry while that register waits
// throughput: one byte per cycle while the skid entry is empty, set by one crc byte step per window cell
// a two-entry output buffer lets bytes in while a result waits to be taken
// reset (rst, synchronous): search mode, empty window, count zero, no result
// pending, sync word back to its default; window bytes themselves not cleared
module sync_word_header_deframer_top
  import swhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  swhd_in_if.sink     rx,
  swhd_out_if.source  res
);

  // configuration
  logic [31:0] sync_word;

  // deframer control state
  logic        in_payload;
  logic [15:0] bytes_remaining;
  logic [4:0]  window_fill;

  // output register and skid entry
  result_t     o_data;
  result_t     s_data;
  logic        o_valid;
  logic        s_valid;

  logic        accept;
  logic        pop;
  logic        push;
  logic        produce;
  result_t     result;

  // cell chain: cell 0 holds the newest byte, cell 15 the oldest
  cell_bus_t   bus;
  logic [7:0]  cell_byte [WIN_BYTES];
  logic [31:0] cell_crc  [WIN_BYTES];

  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic        window_full;
  logic        crc_ok;
  logic        match;

  assign rx.ready = !s_valid;
  assign accept   = rx.valid && rx.ready;

  // window only slides while searching
  assign bus.shift_en = accept && !in_payload;
  // word 3 of the window once the new byte is in, little-endian
  assign bus.word     = {rx.rx_byte, cell_byte[0], cell_byte[1], cell_byte[2]};

  // each cell carries the crc of a header candidate one byte younger than
  // its neighbour; words are folded in at every fourth byte and the last
  // word's shift finishes as word 3 arrives
  genvar i;
  generate
    for (i = 0; i < WIN_BYTES; i++) begin : g_cell
      logic [7:0]  byte_feed;
      logic [31:0] crc_feed;

      if (i == 0) begin : g_head
        assign byte_feed = rx.rx_byte;
        assign crc_feed  = CRC_INIT;
      end else begin : g_body
        assign byte_feed = cell_byte[i-1];
        assign crc_feed  = cell_crc[i-1];
      end

      swhd_cell #(
        .CRC_EN  ((i >= 3) && (i < LAST_CELL)),
        .SEED_EN (i == 3),
        .WORD_EN ((i % 4) == 3)
      ) u_cell (
        .clk      (clk),
        .bus      (bus),
        .byte_in  (byte_feed),
        .crc_in   (crc_feed),
        .byte_out (cell_byte[i]),
        .crc_out  (cell_crc[i])
      );
    end
  endgenerate

  // header words as they stand once the incoming byte has shifted in
  assign word0 = {cell_byte[11], cell_byte[12], cell_byte[13], cell_byte[14]};
  assign word1 = {cell_byte[7],  cell_byte[8],  cell_byte[9],  cell_byte[10]};
  assign word2 = {cell_byte[3],  cell_byte[4],  cell_byte[5],  cell_byte[6]};

  assign window_full = window_fill >= 5'(WIN_BYTES - 1);
  assign crc_ok      = crc_shift8(cell_crc[LAST_CELL-1]) == bus.word;
  assign match       = window_full && (word0 == sync_word) && crc_ok;

  // result for the byte at the input
  always_comb begin
    result  = '0;
    produce = 1'b0;
    if (in_payload) begin
      produce             = 1'b1;
      result.kind         = KIND_PAYLOAD;
      result.payload_byte = rx.rx_byte;
      result.last         = bytes_remaining <= 16'd1;
    end else if (match) begin
      produce                = 1'b1;
      result.kind            = KIND_HEADER;
      result.sequence_number = word1;
      result.payload_length  = word2[15:0];
    end
  end

  assign push = accept && produce;
  assign pop  = o_valid && res.ready;

  // sync word register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= SYNC_RESET;
    end else if (cfg_wr_en) begin
      sync_word <= cfg_wr_data;
    end
  end

  // search and payload control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload      <= 1'b0;
      bytes_remaining <= '0;
      window_fill     <= '0;
    end else if (accept) begin
      if (in_payload) begin
        if (bytes_remaining <= 16'd1) begin
          bytes_remaining <= '0;
          in_payload      <= 1'b0;
          window_fill     <= '0;
        end else begin
          bytes_remaining <= bytes_remaining - 16'd1;
        end
      end else if (match) begin
        // zero length drops straight back to the search
        window_fill     <= '0;
        bytes_remaining <= word2[15:0];
        in_payload      <= word2[15:0] != 16'd0;
      end else if (window_fill < 5'(WIN_BYTES)) begin
        window_fill <= window_fill + 5'd1;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (s_valid) begin
      if (pop) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end
    end else if (push) begin
      if (!o_valid || pop) begin
        o_valid <= 1'b1;
      end else begin
        s_valid <= 1'b1;
      end
    end else if (pop) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid) begin
      if (pop) begin
        o_data <= s_data;
      end
    end else if (push) begin
      if (!o_valid || pop) begin
        o_data <= result;
      end else begin
        s_data <= result;
      end
    end
  end

  assign res.valid           = o_valid;
  assign res.kind            = o_data.kind;
  assign res.sequence_number = o_data.sequence_number;
  assign res.payload_length  = o_data.payload_length;
  assign res.payload_byte    = o_data.payload_byte;
  assign res.last            = o_data.last;

endmodule
